// ----- hdl/text_box_layout_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// Text box layout engine - assertion macros
// Property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_BOX_LAYOUT_ENGINE_CORE_MACROS_SVH
`define TEXT_BOX_LAYOUT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TBLE_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define TBLE_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hdl/tble_pkg.sv -----
// ----------------------------------------------------------------------------
// Text box layout engine - package
// Widths, register indexes, result kinds and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package tble_pkg;

   // Width of the configuration registers
   localparam int COORD_BITS     = 12;
   localparam int CSR_INDEX_BITS = 2;

   // Cell geometry: 8 x 16 pixels
   localparam int CELL_W_SHIFT = 3;
   localparam int CELL_H_SHIFT = 4;

   // Cursor state widths
   localparam int ROW_BITS = 8;
   localparam int COL_BITS = 9;

   // Row and column counts taken from the box size
   localparam int ROWS_BITS = COORD_BITS - CELL_H_SHIFT;
   localparam int COLS_BITS = COORD_BITS - CELL_W_SHIFT;
   localparam int ROW_CMP_BITS = (ROWS_BITS > ROW_BITS) ? ROWS_BITS : ROW_BITS;
   localparam int COL_CMP_BITS = (COLS_BITS > COL_BITS) ? COLS_BITS : COL_BITS;

   // Result field widths
   localparam int POS_BITS   = 13;
   localparam int GLYPH_BITS = 8;
   localparam int SUM_BITS   = 16;

   // Character codes
   localparam logic [GLYPH_BITS-1:0] CHAR_END     = 8'd0;
   localparam logic [GLYPH_BITS-1:0] CHAR_NEWLINE = 8'd10;

   // Reset values of the box registers
   localparam logic [COORD_BITS-1:0] BOX_WIDTH_RESET  = COORD_BITS'(640);
   localparam logic [COORD_BITS-1:0] BOX_HEIGHT_RESET = COORD_BITS'(480);

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int COUNT_BITS  = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIGIN_X   = 2'd0,
      CSR_ORIGIN_Y   = 2'd1,
      CSR_BOX_WIDTH  = 2'd2,
      CSR_BOX_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_DRAW   = 1'b0,
      KIND_RECORD = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [POS_BITS-1:0]     pos_x;
      logic [POS_BITS-1:0]     pos_y;
      logic [GLYPH_BITS-1:0]   glyph;
      logic [ROW_BITS-1:0]     line_index;
      logic [COL_BITS-1:0]     line_length;
      logic                    last_of_item;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/tble_if.sv -----
// ----------------------------------------------------------------------------
// Text box layout engine - channel interfaces
// Valid/ready channels for characters in, results out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Character stream
interface tble_req_if
   import tble_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [GLYPH_BITS-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// Draw commands and line length records
interface tble_rsp_if
   import tble_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [POS_BITS-1:0]   pos_x;
   logic [POS_BITS-1:0]   pos_y;
   logic [GLYPH_BITS-1:0] glyph;
   logic [ROW_BITS-1:0]   line_index;
   logic [COL_BITS-1:0]   line_length;
   logic                  last_of_item;

   modport source (output valid, output kind, output pos_x, output pos_y, output glyph,
                   output line_index, output line_length, output last_of_item,
                   input ready);
   modport sink   (input valid, input kind, input pos_x, input pos_y, input glyph,
                   input line_index, input line_length, input last_of_item,
                   output ready);
endinterface

// Register writes
interface tble_csr_if
   import tble_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COORD_BITS-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- hdl/text_box_layout_engine_core.sv -----
// ----------------------------------------------------------------------------
// Text box layout engine
// Places a character stream in a box of 8x16 cells, issuing draw commands
// and line length records with wrap, row limit and end-of-text handling.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                      transfer
//   req_chan  in   char_code                                    valid & ready
//   rsp_chan  out  kind, pos_x, pos_y, glyph, line_index,       valid & ready
//                  line_length, last_of_item
//   csr_chan  in   index, wdata                                 valid & ready
//
// Each character is laid out in the cycle it is taken; its results go into
// a four-entry queue and go out one per cycle while rsp_chan is ready.
// A character yields 0, 1 or 2 results, so the rate is one character per
// cycle while each yields at most one and rsp_chan is ready; a wrapping
// character yields a record and then a draw. req_chan is ready while fewer
// than three results are queued. Synchronous reset clears cursor and queue
// count, presets the box registers; csr_chan is always ready out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module text_box_layout_engine_core
   import tble_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   tble_req_if.sink   req_chan,
   tble_rsp_if.source rsp_chan,
   tble_csr_if.sink   csr_chan
);

   // Box registers
   logic [COORD_BITS-1:0] origin_x_ff, origin_y_ff, box_width_ff, box_height_ff;

   // Cursor state
   logic [ROW_BITS-1:0] cur_row_ff, cur_row_in;
   logic [COL_BITS-1:0] cur_column_ff, cur_column_in;
   logic                dropped_ff, dropped_in;

   // Result queue
   rsp_type               queue_ff [QUEUE_DEPTH];
   rsp_type               queue_in [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  req_take;
   logic                  rsp_take;
   logic [ROWS_BITS-1:0]  rows;
   logic [COLS_BITS-1:0]  columns;
   logic                  rec_en, draw_en;
   rsp_type               rec_res, draw_res, res0, res1;
   logic [1:0]            push_n;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   assign rows    = box_height_ff[COORD_BITS-1:CELL_H_SHIFT];
   assign columns = box_width_ff[COORD_BITS-1:CELL_W_SHIFT];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         box_width_ff  <= BOX_WIDTH_RESET;
         box_height_ff <= BOX_HEIGHT_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_ORIGIN_X:   origin_x_ff   <= csr_chan.wdata;
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_chan.wdata;
            CSR_BOX_WIDTH:  box_width_ff  <= csr_chan.wdata;
            CSR_BOX_HEIGHT: box_height_ff <= csr_chan.wdata;
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = !reset;

   // Layout of one character: at most a record, then a draw
   always_comb begin
      logic                    row_in_box;
      logic                    wrap;
      logic [ROW_BITS-1:0]     row1;
      logic [COL_BITS-1:0]     col1;
      logic [SUM_BITS-1:0]     x_sum, y_sum;
      logic [COL_BITS-1:0]     rec_len;

      row_in_box = ROW_CMP_BITS'(cur_row_ff) < ROW_CMP_BITS'(rows);
      wrap       = COL_CMP_BITS'(cur_column_ff) >= COL_CMP_BITS'(columns);
      row1       = cur_row_ff;
      col1       = cur_column_ff;
      rec_len    = cur_column_ff;
      rec_en     = 1'b0;
      draw_en    = 1'b0;

      cur_row_in    = cur_row_ff;
      cur_column_in = cur_column_ff;
      dropped_in    = dropped_ff;

      if (req_chan.char_code == CHAR_END) begin
         // end of text: last line's length, then back to the start
         rec_en        = !dropped_ff && row_in_box;
         cur_row_in    = '0;
         cur_column_in = '0;
         dropped_in    = 1'b0;
      end else if (dropped_ff) begin
         // past the row limit: ignore until end of text
      end else if (req_chan.char_code == CHAR_NEWLINE) begin
         rec_en        = row_in_box;
         cur_row_in    = (cur_row_ff != '1) ? cur_row_ff + 1'b1 : cur_row_ff;
         cur_column_in = '0;
      end else begin
         // wrap a full line first
         if (wrap) begin
            rec_en  = row_in_box;
            rec_len = COL_BITS'(columns);
            row1    = (cur_row_ff != '1) ? cur_row_ff + 1'b1 : cur_row_ff;
            col1    = '0;
         end
         cur_row_in    = row1;
         cur_column_in = col1;
         if (ROW_CMP_BITS'(row1) >= ROW_CMP_BITS'(rows)) begin
            dropped_in = 1'b1;
         end else begin
            draw_en       = 1'b1;
            cur_column_in = col1 + 1'b1;
         end
      end

      x_sum = SUM_BITS'({col1, {CELL_W_SHIFT{1'b0}}}) + SUM_BITS'(origin_x_ff);
      y_sum = SUM_BITS'({row1, {CELL_H_SHIFT{1'b0}}}) + SUM_BITS'(origin_y_ff);

      rec_res              = '0;
      rec_res.kind         = KIND_RECORD;
      rec_res.line_index   = cur_row_ff;
      rec_res.line_length  = rec_len;
      rec_res.last_of_item = !draw_en;

      draw_res              = '0;
      draw_res.kind         = KIND_DRAW;
      draw_res.pos_x        = x_sum[POS_BITS-1:0];
      draw_res.pos_y        = y_sum[POS_BITS-1:0];
      draw_res.glyph        = req_chan.char_code;
      draw_res.last_of_item = 1'b1;

      res0   = rec_en ? rec_res : draw_res;
      res1   = draw_res;
      push_n = req_take ? (2'(rec_en) + 2'(draw_en)) : 2'd0;
   end

   // Cursor update on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff    <= '0;
         cur_column_ff <= '0;
         dropped_ff    <= 1'b0;
      end else if (req_take) begin
         cur_row_ff    <= cur_row_in;
         cur_column_ff <= cur_column_in;
         dropped_ff    <= dropped_in;
      end
   end

   // Queue: pop from the head, append up to two behind the survivors
   always_comb begin
      rsp_type               shifted [QUEUE_DEPTH];
      logic [COUNT_BITS-1:0] base;

      shifted = queue_ff;
      if (rsp_take) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            shifted[i] = queue_ff[i+1];
         end
      end
      base     = count_ff - COUNT_BITS'(rsp_take);
      queue_in = shifted;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push_n != 2'd0 && base == COUNT_BITS'(i)) begin
            queue_in[i] = res0;
         end
         if (push_n == 2'd2 && base + 1'b1 == COUNT_BITS'(i)) begin
            queue_in[i] = res1;
         end
      end
      count_in = base + COUNT_BITS'(push_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // Room for two more results whatever the output side does
   assign req_chan.ready = !reset && (count_ff < COUNT_BITS'(QUEUE_DEPTH - 1));

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.kind         = queue_ff[0].kind;
   assign rsp_chan.pos_x        = queue_ff[0].pos_x;
   assign rsp_chan.pos_y        = queue_ff[0].pos_y;
   assign rsp_chan.glyph        = queue_ff[0].glyph;
   assign rsp_chan.line_index   = queue_ff[0].line_index;
   assign rsp_chan.line_length  = queue_ff[0].line_length;
   assign rsp_chan.last_of_item = queue_ff[0].last_of_item;

endmodule

`default_nettype wire

// ----- hdl/tble_checker.sv -----
// ----------------------------------------------------------------------------
// Text box layout engine - port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_box_layout_engine_core_macros.svh"

module tble_checker
   import tble_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire                  rsp_kind,
   input wire [POS_BITS-1:0]   rsp_pos_x,
   input wire [POS_BITS-1:0]   rsp_pos_y,
   input wire [GLYPH_BITS-1:0] rsp_glyph,
   input wire [ROW_BITS-1:0]   rsp_line_index,
   input wire [COL_BITS-1:0]   rsp_line_length,
   input wire                  rsp_last_of_item
);

   // Stalled result holds
   `TBLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_kind, rsp_pos_x, rsp_pos_y, rsp_glyph, rsp_line_index, rsp_line_length, rsp_last_of_item}), "stalled result changed")
   // A record that is not last is the wrap record; its draw follows at once
   `TBLE_ASSERT_NEXT(a_wrap_draw, clock, reset, rsp_valid && rsp_ready && rsp_kind == KIND_RECORD && !rsp_last_of_item, rsp_valid && rsp_kind == KIND_DRAW && rsp_last_of_item, "wrap record without its draw")
   // A draw always closes its character
   `TBLE_ASSERT_NOW(a_draw_last, clock, reset, rsp_valid && rsp_kind == KIND_DRAW, rsp_last_of_item && rsp_line_index == '0 && rsp_line_length == '0, "draw result malformed")
   // Records carry no position or glyph
   `TBLE_ASSERT_NOW(a_rec_clean, clock, reset, rsp_valid && rsp_kind == KIND_RECORD, rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_glyph == '0, "record result malformed")

endmodule

bind text_box_layout_engine_core tble_checker u_tble_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_pos_x        (rsp_chan.pos_x),
   .rsp_pos_y        (rsp_chan.pos_y),
   .rsp_glyph        (rsp_chan.glyph),
   .rsp_line_index   (rsp_chan.line_index),
   .rsp_line_length  (rsp_chan.line_length),
   .rsp_last_of_item (rsp_chan.last_of_item)
);

`default_nettype wire

// ----- tb/text_box_layout_engine_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text box layout engine - testbench
// Streams text through the layout core and checks every draw command and
// line record against a cycle-free layout predictor kept in the bench.
// Covers wrap, row limit, dropped text, end of text and box size extremes.
// Random gaps are applied on both sides.
// ----------------------------------------------------------------------------

module text_box_layout_engine_core_tb
   import tble_pkg::*;
();

   logic clock = 1'b0;
   logic reset;

   tble_req_if req_chan ();
   tble_rsp_if rsp_chan ();
   tble_csr_if csr_chan ();

   text_box_layout_engine_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor copy of the box registers and cursor
   logic [COORD_BITS-1:0] origin_x_r, origin_y_r, box_width_r, box_height_r;
   logic [ROW_BITS-1:0]   cur_row;
   logic [COL_BITS-1:0]   cur_col;
   logic                  text_dropped;

   logic [GLYPH_BITS-1:0] text_chars[$];   // characters waiting to be sent
   rsp_type               box_results[$];  // draws and records still due

   logic char_taken   = 1'b0;
   logic result_taken = 1'b0;
   logic steady_flow  = 1'b0;              // no idling on either side
   int   char_gap     = 0;
   int   result_stall = 0;
   int   mismatches   = 0;
   int   chars_sent   = 0;
   int   draws_seen   = 0;
   int   records_seen = 0;
   int   box_settings = 0;

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   function automatic rsp_type make_record(logic [ROW_BITS-1:0] row, int len);
      rsp_type r;
      r              = '0;
      r.kind         = KIND_RECORD;
      r.line_index   = row;
      r.line_length  = COL_BITS'(len);
      return r;
   endfunction

   // Next row, saturating at the top of the row counter
   function automatic void advance_row();
      if (cur_row != '1)
         cur_row = cur_row + 1'b1;
      cur_col = '0;
   endfunction

   // Lay out one character and queue the results it causes
   task automatic lay_out_char(logic [GLYPH_BITS-1:0] c);
      int      rows, cols;
      rsp_type due[$];
      rsp_type d;
      rows = int'(box_height_r) / 16;
      cols = int'(box_width_r) / 8;
      if (c == CHAR_END) begin
         if (!text_dropped && cur_row < rows)
            due.push_back(make_record(cur_row, cur_col));
         cur_row      = '0;
         cur_col      = '0;
         text_dropped = 1'b0;
      end else if (text_dropped) begin
         // ignored until the end of the text
      end else if (c == CHAR_NEWLINE) begin
         if (cur_row < rows)
            due.push_back(make_record(cur_row, cur_col));
         advance_row();
      end else begin
         // wrap: record a full row first
         if (cur_col >= cols) begin
            if (cur_row < rows)
               due.push_back(make_record(cur_row, cols));
            advance_row();
         end
         if (cur_row >= rows) begin
            text_dropped = 1'b1;
         end else begin
            d       = '0;
            d.kind  = KIND_DRAW;
            d.pos_x = POS_BITS'(int'(cur_col) * 8 + int'(origin_x_r));
            d.pos_y = POS_BITS'(int'(cur_row) * 16 + int'(origin_y_r));
            d.glyph = c;
            due.push_back(d);
            cur_col = cur_col + 1'b1;
         end
      end
      if (due.size() > 0)
         due[due.size()-1].last_of_item = 1'b1;
      foreach (due[i])
         box_results.push_back(due[i]);
   endtask

   // Transfers are sampled at the rising edge; prediction and checking
   always @(posedge clock) begin : sample_transfers
      rsp_type got, want;
      char_taken   = !reset && req_chan.valid && req_chan.ready;
      result_taken = !reset && rsp_chan.valid && rsp_chan.ready;
      if (char_taken)
         lay_out_char(req_chan.char_code);
      if (result_taken) begin
         got.kind         = kind_type'(rsp_chan.kind);
         got.pos_x        = rsp_chan.pos_x;
         got.pos_y        = rsp_chan.pos_y;
         got.glyph        = rsp_chan.glyph;
         got.line_index   = rsp_chan.line_index;
         got.line_length  = rsp_chan.line_length;
         got.last_of_item = rsp_chan.last_of_item;
         if (box_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d", got.kind));
         end else begin
            want = box_results.pop_front();
            if (want.kind == KIND_DRAW)
               draws_seen++;
            else
               records_seen++;
            if (got.kind !== want.kind || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.glyph !== want.glyph ||
                got.line_index !== want.line_index ||
                got.line_length !== want.line_length ||
                got.last_of_item !== want.last_of_item)
               report_mismatch($sformatf(
                  "got k%0d x%0d y%0d g%0d row%0d len%0d last%0d, want k%0d x%0d y%0d g%0d row%0d len%0d last%0d",
                  got.kind, got.pos_x, got.pos_y, got.glyph, got.line_index,
                  got.line_length, got.last_of_item,
                  want.kind, want.pos_x, want.pos_y, want.glyph, want.line_index,
                  want.line_length, want.last_of_item));
         end
      end
   end

   // Character driver: one item per transfer, random gap before the next
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || char_taken) begin
         if (char_gap > 0 || text_chars.size() == 0) begin
            req_chan.valid <= 1'b0;
            if (char_gap > 0)
               char_gap--;
         end else begin
            req_chan.valid     <= 1'b1;
            req_chan.char_code <= text_chars.pop_front();
            char_gap = steady_flow ? 0 : $urandom_range(0, 3);
         end
      end
   end

   // Result sink: random stall after each transfer
   always @(negedge clock) begin
      if (result_taken)
         result_stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (result_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         result_stall--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic write_box_reg(csr_index_type idx, logic [COORD_BITS-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= value;
      @(posedge clock);
      while (!csr_chan.ready)
         @(posedge clock);
      case (idx)
         CSR_ORIGIN_X:   origin_x_r   = value;
         CSR_ORIGIN_Y:   origin_y_r   = value;
         CSR_BOX_WIDTH:  box_width_r  = value;
         CSR_BOX_HEIGHT: box_height_r = value;
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_box(int ox, int oy, int w, int h);
      write_box_reg(CSR_ORIGIN_X, COORD_BITS'(ox));
      write_box_reg(CSR_ORIGIN_Y, COORD_BITS'(oy));
      write_box_reg(CSR_BOX_WIDTH, COORD_BITS'(w));
      write_box_reg(CSR_BOX_HEIGHT, COORD_BITS'(h));
      box_settings++;
   endtask

   // Wait until everything sent has been laid out and every result has arrived
   task automatic drain_results();
      @(posedge clock);
      while (text_chars.size() != 0 || req_chan.valid || box_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_char(logic [GLYPH_BITS-1:0] c);
      text_chars.push_back(c);
      chars_sent++;
   endtask

   task automatic queue_string(string s);
      for (int i = 0; i < s.len(); i++)
         queue_char(GLYPH_BITS'(s[i]));
   endtask

   function automatic logic [GLYPH_BITS-1:0] printable_char();
      logic [GLYPH_BITS-1:0] c;
      do
         c = GLYPH_BITS'($urandom_range(1, 255));
      while (c == CHAR_NEWLINE);
      return c;
   endfunction

   function automatic int pick_origin();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return (1 << COORD_BITS) - 1;
         default: return $urandom_range(0, (1 << COORD_BITS) - 1);
      endcase
   endfunction

   initial begin : stimulus
      int w, h, rows, cols, n_lines, len, n_texts;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_ORIGIN_X;
      csr_chan.wdata     = '0;
      origin_x_r         = '0;
      origin_y_r         = '0;
      box_width_r        = BOX_WIDTH_RESET;
      box_height_r       = BOX_HEIGHT_RESET;
      cur_row            = '0;
      cur_col            = '0;
      text_dropped       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset box: plain text, newline, top glyph codes, end right after end
      queue_string("Hi");
      queue_char(CHAR_NEWLINE);
      queue_char(8'd255);
      queue_char(8'd1);
      queue_char(8'd128);
      queue_char(CHAR_END);
      queue_char(CHAR_END);
      drain_results();

      // 2x2 box at the far corner: wrap, drop at the row limit, ignored text
      set_box(4095, 4095, 16, 32);
      queue_string("ABCDEF");
      queue_char(CHAR_NEWLINE);
      queue_char(CHAR_END);
      queue_char(CHAR_NEWLINE);
      queue_char(CHAR_END);
      drain_results();

      // No columns: wraps with an empty record, then drops
      set_box(0, 0, 0, 16);
      queue_string("x");
      queue_char(CHAR_END);
      drain_results();

      // No rows: records suppressed and text dropped at once
      set_box(0, 0, 4095, 0);
      queue_char(CHAR_NEWLINE);
      queue_string("q");
      queue_char(CHAR_END);
      drain_results();

      // Tall box: newlines past the row counter limit must saturate it
      set_box(pick_origin(), pick_origin(), 4095, 4095);
      steady_flow = 1'b1;
      repeat (257) queue_char(CHAR_NEWLINE);
      queue_char(printable_char());
      queue_char(CHAR_END);
      drain_results();

      // Random boxes and texts, the sender waits for all results between boxes
      while (chars_sent < 600) begin
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 15);
            1:       w = 4095;
            default: w = $urandom_range(8, 200);
         endcase
         case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 31);
            1:       h = 4095;
            default: h = $urandom_range(16, 160);
         endcase
         set_box(pick_origin(), pick_origin(), w, h);
         steady_flow = ($urandom_range(0, 3) == 0);
         rows    = h / 16;
         cols    = w / 8;
         n_texts = $urandom_range(1, 3);
         repeat (n_texts) begin
            if ($urandom_range(0, 6) != 0) begin
               // well formed text: lines around the box size, then an end code
               n_lines = $urandom_range(1, (rows + 2 < 6) ? rows + 2 : 6);
               for (int l = 0; l < n_lines; l++) begin
                  len = $urandom_range(0, (cols + 2 < 40) ? cols + 2 : 40);
                  repeat (len) queue_char(printable_char());
                  if (l < n_lines - 1)
                     queue_char(CHAR_NEWLINE);
               end
               queue_char(CHAR_END);
            end else begin
               // noise: arbitrary bytes, end codes and newlines favoured
               repeat ($urandom_range(1, 20)) begin
                  case ($urandom_range(0, 4))
                     0:       queue_char(CHAR_END);
                     1:       queue_char(CHAR_NEWLINE);
                     default: queue_char(GLYPH_BITS'($urandom_range(0, 255)));
                  endcase
               end
            end
         end
         drain_results();
      end

      steady_flow = 1'b0;
      repeat (8) @(posedge clock);
      $display("Run covered %0d characters over %0d box settings,", chars_sent, box_settings);
      $display("checking %0d draw commands and %0d line records.", draws_seen, records_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Hard limit on the run
   initial begin
      #1000000;
      $display("Timeout with %0d results outstanding", box_results.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
